[src/bpa_pkg.sv]
// shared constants and control types for the bitmap page allocator
package bpa_pkg;

  // page space and bitmap geometry
  localparam int TOTAL_PAGES = 4096;
  localparam int WORD_BITS   = 32;
  localparam int WORD_COUNT  = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;

  // derived widths
  localparam int PAGE_W  = $clog2(TOTAL_PAGES);
  localparam int COUNT_W = $clog2(TOTAL_PAGES + 1);
  localparam int WIDX_W  = $clog2(WORD_COUNT);
  localparam int BIT_W   = $clog2(WORD_BITS);

  // request modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear_wr;   // write an all-free word at the word index, step index
    logic start;      // capture request, rewind search
    logic decide_rel; // release accepted: point at first word of the run
    logic rd;         // read bitmap word at the word index
    logic chk;        // evaluate the scanned word
    logic mark_wr;    // write back the marked word, step index
    logic finish;     // update count and load the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic word_last;  // word index at the last bitmap word
    logic req_bad;    // captured request cannot succeed
    logic rel;        // captured request is a release
    logic hit;        // scanned word completes a free run
    logic mark_last;  // word index at the last word of the run
  } sts_t;

endpackage

[src/bpa_ctrl.sv]
// sequencer for clearing, scanning and marking the page bitmap
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  input  bpa_pkg::sts_t  sts,
  output bpa_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DECIDE   = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_MARK_RD  = 3'd5;
  localparam logic [2:0] S_MARK_WR  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;
  logic       out_free;

  // result register can take a new word
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.word_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.req_bad) begin
          state_next = S_DONE;
        end else if (sts.rel) begin
          cmd.decide_rel = 1'b1;
          state_next     = S_MARK_RD;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.chk = 1'b1;
        priority if (sts.hit) state_next = S_MARK_RD;
        else if (sts.word_last) state_next = S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_MARK_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        if (sts.mark_last) state_next = S_DONE;
        else state_next = S_MARK_RD;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // result valid flag
  always_comb begin
    priority if (cmd.finish) rsp_valid_next = 1'b1;
    else if (!rsp_stall) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_decides: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DECIDE))
    else $error("accepted request did not move to decide");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done state");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("stalled result word dropped");

  a_clear_blocks_requests: assert property (@(posedge clk)
    (state == S_CLEAR) |-> req_stall)
    else $error("request taken during clearing pass");
`endif

endmodule

[src/bpa_dpath.sv]
// bitmap memory, run search, run marking, free count and result register
module bpa_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  bpa_pkg::cmd_t                cmd,
  output bpa_pkg::sts_t                sts,
  input  logic                         mode,
  input  logic [bpa_pkg::PAGE_W-1:0]   first_page,
  input  logic [bpa_pkg::COUNT_W-1:0]  run_length,
  output logic                         ok,
  output logic [bpa_pkg::PAGE_W-1:0]   granted_page,
  output logic [bpa_pkg::COUNT_W-1:0]  free_pages
);

  localparam int W   = bpa_pkg::WORD_BITS;
  localparam int CW  = bpa_pkg::COUNT_W;
  localparam int PW  = bpa_pkg::PAGE_W;
  localparam int XW  = bpa_pkg::WIDX_W;
  localparam int BW  = bpa_pkg::BIT_W;
  localparam logic [CW:0]   TOTAL_X = (CW + 1)'(bpa_pkg::TOTAL_PAGES);
  localparam logic [XW-1:0] LAST_W  = XW'(bpa_pkg::WORD_COUNT - 1);

  // bitmap store, one bit per page, 1 = free
  logic [W-1:0] mem [bpa_pkg::WORD_COUNT];
  logic [W-1:0] rd_data;
  logic [W-1:0] wr_data;

  // request and walk registers
  logic          req_mode;
  logic [CW-1:0] req_len;
  logic [PW-1:0] req_first;
  logic [XW-1:0] widx;
  logic [CW-1:0] run;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  logic          ok_flag;
  logic [CW-1:0] free_count;

  // search signals
  logic [W-1:0]  vmask;
  logic [W-1:0]  word;
  logic [W-1:0]  pre;
  logic [W-1:0]  suf;
  logic [W-1:0]  top_mask;
  logic [W-1:0]  hit_vec;
  logic [BW-1:0] hit_idx;
  logic [CW-1:0] run_next;
  logic [PW-1:0] end_page;
  logic [PW-1:0] granted;

  // marking signals
  logic [XW-1:0] lo_w;
  logic [XW-1:0] hi_w;
  logic [BW-1:0] lb;
  logic [BW-1:0] hb;
  logic [W-1:0]  mmask;

  // request checks
  logic [CW:0]   rel_end;
  logic [CW:0]   cnt_sum;
  logic [CW-1:0] count_next;

  assign rel_end = {1'b0, req_first} + {1'b0, req_len};

  assign sts.word_last = (widx == LAST_W);
  assign sts.rel       = (req_mode == bpa_pkg::MODE_RELEASE);
  assign sts.req_bad   = (req_len == '0) ||
                         ((req_mode == bpa_pkg::MODE_ALLOC) ? ({1'b0, req_len} > TOTAL_X)
                                                            : (rel_end > TOTAL_X));
  assign sts.hit       = |hit_vec;
  assign sts.mark_last = (widx == hi_w);

  // first-fit search over one bitmap word
  always_comb begin
    logic [W-1:0]  sh;
    logic [CW:0]   pos;
    logic [CW:0]   run_sum;
    logic [XW+BW:0] pg;
    logic [CW:0]   g_full;
    for (int b = 0; b < W; b++) begin
      pg       = (XW + BW + 1)'({widx, BW'(b)});
      vmask[b] = ((CW + 1)'(pg) < TOTAL_X);
    end
    word   = rd_data & vmask;
    pre[0] = word[0];
    for (int i = 1; i < W; i++) pre[i] = pre[i-1] & word[i];
    suf[W-1] = word[W-1];
    for (int i = W - 2; i >= 0; i--) suf[i] = suf[i+1] & word[i];
    top_mask = ~({W{1'b1}} >> req_len);
    for (int i = 0; i < W; i++) begin
      sh  = word << (W - 1 - i);
      pos = (CW + 1)'(i + 1);
      if ({1'b0, req_len} <= pos) hit_vec[i] = ((sh & top_mask) == top_mask);
      else hit_vec[i] = pre[i] && (({1'b0, run} + pos) >= {1'b0, req_len});
    end
    hit_idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = BW'(i);
    end
    // run carried into the next word
    run_sum = {1'b0, run} + (CW + 1)'(W);
    if (&word) run_next = (run_sum > TOTAL_X) ? TOTAL_X[CW-1:0] : run_sum[CW-1:0];
    else run_next = CW'($countones(suf));
    end_page = PW'({widx, hit_idx});
    g_full   = (CW + 1)'(end_page) + (CW + 1)'(1) - {1'b0, req_len};
    granted  = g_full[PW-1:0];
  end

  // range mask of the run within the current word
  always_comb begin
    lo_w = XW'(lo >> BW);
    hi_w = XW'(hi >> BW);
    lb   = (widx == lo_w) ? lo[BW-1:0] : '0;
    hb   = (widx == hi_w) ? hi[BW-1:0] : '1;
    for (int b = 0; b < W; b++) mmask[b] = (BW'(b) >= lb) && (BW'(b) <= hb);
    if (cmd.clear_wr) wr_data = '1;
    else if (req_mode == bpa_pkg::MODE_RELEASE) wr_data = rd_data | mmask;
    else wr_data = rd_data & ~mmask;
  end

  // new free count, saturating both ways
  always_comb begin
    cnt_sum = {1'b0, free_count} + {1'b0, req_len};
    if (!ok_flag) count_next = free_count;
    else if (req_mode == bpa_pkg::MODE_RELEASE)
      count_next = (cnt_sum > TOTAL_X) ? TOTAL_X[CW-1:0] : cnt_sum[CW-1:0];
    else count_next = (free_count >= req_len) ? (free_count - req_len) : '0;
  end

  // bitmap memory ports
  always_ff @(posedge clk) begin
    if (cmd.clear_wr || cmd.mark_wr) mem[widx] <= wr_data;
    if (cmd.rd) rd_data <= mem[widx];
  end

  // walk state and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      widx       <= '0;
      ok_flag    <= 1'b0;
      free_count <= TOTAL_X[CW-1:0];
    end else begin
      if (cmd.clear_wr || cmd.mark_wr) widx <= widx + XW'(1);
      if (cmd.start) begin
        widx    <= '0;
        ok_flag <= 1'b0;
      end
      if (cmd.decide_rel) begin
        widx    <= lo_w;
        ok_flag <= 1'b1;
      end
      if (cmd.chk) begin
        if (sts.hit) begin
          widx    <= XW'(granted >> BW);
          ok_flag <= 1'b1;
        end else begin
          widx <= widx + XW'(1);
        end
      end
      if (cmd.finish) free_count <= count_next;
    end
  end

  // request capture, run bounds and search run
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_mode  <= mode;
      req_first <= first_page;
      req_len   <= run_length;
      lo        <= first_page;
      hi        <= PW'(({1'b0, first_page} + {1'b0, run_length}) - (CW + 1)'(1));
      run       <= '0;
    end
    if (cmd.chk) begin
      if (sts.hit) begin
        lo <= granted;
        hi <= end_page;
      end else begin
        run <= run_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ok           <= ok_flag;
      granted_page <= (ok_flag && req_mode == bpa_pkg::MODE_ALLOC) ? lo : '0;
      free_pages   <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, free_count} <= TOTAL_X))
    else $error("free count above page total");
`endif

endmodule

[src/bitmap_page_allocator.sv]
// bitmap first-fit page allocator
// request channel: req_valid / req_stall carry mode, first_page and run_length;
//   mode 0 allocates the lowest run of run_length free pages, mode 1 frees the
//   run of run_length pages starting at first_page
// response channel: rsp_valid / rsp_stall carry ok, granted_page (first page of
//   the allocated run, 0 on failure or release) and free_pages after the request
// exactly one response word per request word, in order; one request in flight
// steps: the request is checked; an allocation then scans the bitmap one word at a time
//   (up to 128 words) for a free run; the words touched by the run are then read and
//   rewritten one by one, and the response word is loaded
// a new request is taken only once the last one is through; the request rate is set
//   by the single-port bitmap memory read and written one 32-page word at a time
// after reset a clearing pass marks every page free; req_stall stays high
//   meanwhile
// a pending response sits in an output register; the next request is taken while
//   it waits, but its own result holds until rsp_stall drops
module bitmap_page_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         mode,
  input  logic [bpa_pkg::PAGE_W-1:0]   first_page,
  input  logic [bpa_pkg::COUNT_W-1:0]  run_length,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         ok,
  output logic [bpa_pkg::PAGE_W-1:0]   granted_page,
  output logic [bpa_pkg::COUNT_W-1:0]  free_pages
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bitmap and arithmetic
  bpa_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .first_page   (first_page),
    .run_length   (run_length),
    .ok           (ok),
    .granted_page (granted_page),
    .free_pages   (free_pages)
  );

endmodule

[verif/bpa_checker.sv]
`timescale 1ns / 100ps

// watches both channels of the page allocator, predicts every reply word and
// compares it field by field with what the block returns
module bpa_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic                        mode,
  input  logic [bpa_pkg::PAGE_W-1:0]  first_page,
  input  logic [bpa_pkg::COUNT_W-1:0] run_length,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic                        ok,
  input  logic [bpa_pkg::PAGE_W-1:0]  granted_page,
  input  logic [bpa_pkg::COUNT_W-1:0] free_pages,
  output int                          mismatches,
  output int                          replies_owed
);

  typedef struct packed {
    logic                        ok;
    logic [bpa_pkg::PAGE_W-1:0]  page;
    logic [bpa_pkg::COUNT_W-1:0] free;
  } reply_t;

  // private copy of the allocator state, one bit per page (1 = free)
  bit     page_free [bpa_pkg::TOTAL_PAGES];
  int     free_total;
  reply_t owed_replies [$];
  int     mismatch_count = 0;
  int     owed_count = 0;

  assign mismatches   = mismatch_count;
  assign replies_owed = owed_count;

  // keep the log short when the block is badly off, but count everything
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // first-fit allocate or release on the private bitmap, returns the reply word
  function automatic reply_t apply_request(input logic m,
                                           input logic [bpa_pkg::PAGE_W-1:0] fp,
                                           input logic [bpa_pkg::COUNT_W-1:0] len);
    reply_t r;
    int     n;
    int     first;
    int     run;
    int     start;
    int     p;
    r     = '0;
    n     = len;
    first = fp;
    if (m == bpa_pkg::MODE_ALLOC) begin
      if (n != 0 && n <= bpa_pkg::TOTAL_PAGES) begin
        run   = 0;
        start = -1;
        for (p = 0; p < bpa_pkg::TOTAL_PAGES && start < 0; p++) begin
          if (page_free[p]) begin
            run++;
            if (run == n)
              start = p + 1 - n;
          end else begin
            run = 0;
          end
        end
        if (start >= 0) begin
          for (p = start; p < start + n; p++)
            page_free[p] = 1'b0;
          free_total = (free_total >= n) ? free_total - n : 0;
          r.ok   = 1'b1;
          r.page = start[bpa_pkg::PAGE_W-1:0];
        end
      end
    end else begin
      // release: pages already free stay free, count saturates at the total
      if (n != 0 && first + n <= bpa_pkg::TOTAL_PAGES) begin
        for (p = first; p < first + n; p++)
          page_free[p] = 1'b1;
        free_total = free_total + n;
        if (free_total > bpa_pkg::TOTAL_PAGES)
          free_total = bpa_pkg::TOTAL_PAGES;
        r.ok = 1'b1;
      end
    end
    r.free = free_total[bpa_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      foreach (page_free[p])
        page_free[p] = 1'b1;
      free_total = bpa_pkg::TOTAL_PAGES;
      owed_replies.delete();
    end else begin
      // a reply word always belongs to an older request word
      if (rsp_valid && !rsp_stall) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("reply word with no request waiting for it");
        end else begin
          want = owed_replies.pop_front();
          if (ok !== want.ok)
            report_mismatch($sformatf("ok got %b want %b", ok, want.ok));
          if (granted_page !== want.page)
            report_mismatch($sformatf("granted_page got %0d want %0d",
                                      granted_page, want.page));
          if (free_pages !== want.free)
            report_mismatch($sformatf("free_pages got %0d want %0d",
                                      free_pages, want.free));
        end
      end
      if (req_valid && !req_stall)
        owed_replies.push_back(apply_request(mode, first_page, run_length));
    end
    owed_count = owed_replies.size();
  end

endmodule

[verif/bitmap_page_allocator_tb.sv]
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;

  localparam int PW = bpa_pkg::PAGE_W;
  localparam int CW = bpa_pkg::COUNT_W;
  localparam int IDLE_LIMIT = 8000;
  localparam int TAIL_CYCLES = 600;
  localparam int RANDOM_WORDS = 930;
  localparam int HOLD_OFF_AFTER = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               mode = bpa_pkg::MODE_ALLOC;
  logic [PW-1:0]      first_page = '0;
  logic [CW-1:0]      run_length = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic               ok;
  logic [PW-1:0]      granted_page;
  logic [CW-1:0]      free_pages;
  int                 mismatches;
  int                 replies_owed;
  int                 idle_cycles = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bitmap_page_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .first_page   (first_page),
    .run_length   (run_length),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .ok           (ok),
    .granted_page (granted_page),
    .free_pages   (free_pages)
  );

  bpa_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .first_page   (first_page),
    .run_length   (run_length),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .ok           (ok),
    .granted_page (granted_page),
    .free_pages   (free_pages),
    .mismatches   (mismatches),
    .replies_owed (replies_owed)
  );

  // watchdog: ends the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sender gap: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(30, 90);
  endfunction

  // offer one request word; entered and left at a falling edge
  task automatic issue_request(input logic m, input logic [PW-1:0] fp,
                               input logic [CW-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= m;
    first_page <= fp;
    run_length <= len;
    do
      @(posedge clk);
    while (req_stall);
    @(negedge clk);
  endtask

  // reply side: random stall patterns plus one long hold-off to back the block up
  initial begin : reply_sink
    int r;
    int span;
    int clock_count;
    bit held_off;
    clock_count = 0;
    held_off    = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_off && clock_count > HOLD_OFF_AFTER) begin
        rsp_stall <= 1'b1;
        repeat (1500) @(negedge clk);
        clock_count += 1500;
        held_off = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          rsp_stall <= 1'b0;
          span = $urandom_range(1, 30);
        end else if (r < 48) begin
          rsp_stall <= 1'b0;
          span = $urandom_range(100, 300);
        end else if (r < 92) begin
          rsp_stall <= 1'b1;
          span = $urandom_range(1, 4);
        end else begin
          rsp_stall <= 1'b1;
          span = $urandom_range(20, 80);
        end
        repeat (span) @(negedge clk);
        clock_count += span;
      end
    end
  end

  // stimulus and verdict
  initial begin : request_source
    int i;
    int sel;
    int fp;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero length, full allocation, oversize and out-of-range runs
    issue_request(bpa_pkg::MODE_ALLOC, 12'd4095, 13'd0);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd0, 13'd0);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd4096);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd1);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd4095, 13'd2);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd1, 13'd4096);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd0, 13'd4096);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd4097);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd2730, 13'd8191);
    // release of pages already free: count saturates
    issue_request(bpa_pkg::MODE_RELEASE, 12'd4095, 13'd1);
    // first fit, runs spanning a word boundary, holes too small to use
    issue_request(bpa_pkg::MODE_ALLOC, 12'd1365, 13'd1);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd30);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd3);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd0, 13'd1);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd2);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd1);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd4064, 13'd32);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd4000);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd61);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd60);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd2048, 13'd2048);
    issue_request(bpa_pkg::MODE_ALLOC, 12'd0, 13'd2048);
    issue_request(bpa_pkg::MODE_RELEASE, 12'd0, 13'd4096);

    // random mix weighted towards small allocations so the bitmap fills and fragments
    for (i = 0; i < RANDOM_WORDS; i++) begin
      sel = $urandom_range(0, 99);
      fp  = $urandom_range(0, bpa_pkg::TOTAL_PAGES - 1);
      if (sel < 55)
        issue_request(bpa_pkg::MODE_ALLOC, PW'(fp), CW'($urandom_range(1, 48)));
      else if (sel < 62)
        issue_request(bpa_pkg::MODE_ALLOC, PW'(fp), CW'($urandom_range(49, 700)));
      else if (sel < 64)
        issue_request(bpa_pkg::MODE_ALLOC, PW'(fp), CW'($urandom_range(701, 8191)));
      else if (sel < 66)
        issue_request(1'($urandom_range(0, 1)), PW'(fp), 13'd0);
      else if (sel < 92)
        issue_request(bpa_pkg::MODE_RELEASE, PW'(fp), CW'($urandom_range(1, 64)));
      else if (sel < 96)
        issue_request(bpa_pkg::MODE_RELEASE, PW'(fp), CW'($urandom_range(1, 8191)));
      else if (sel < 99)
        issue_request(bpa_pkg::MODE_RELEASE, PW'(fp), CW'(bpa_pkg::TOTAL_PAGES - fp));
      else
        issue_request(bpa_pkg::MODE_RELEASE, 12'd0, CW'(bpa_pkg::TOTAL_PAGES));
    end
    req_valid <= 1'b0;

    // drain, then a tail long enough for a stray word to show up
    while (replies_owed != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[bitmap_page_allocator.f]
src/bpa_pkg.sv
src/bpa_ctrl.sv
src/bpa_dpath.sv
src/bitmap_page_allocator.sv
verif/bpa_checker.sv
verif/bitmap_page_allocator_tb.sv
